// ===== design/p2c_pkg.sv =====
package p2c_pkg;

    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MAX_PLANES        = 24;

    localparam int PLANE_W    = 64;
    localparam int PLANE_BITS = 3 * PLANE_W;
    localparam int PAL_IDX_W  = 8;
    localparam int RGB_W      = 24;
    localparam int FMT_W      = 3;
    localparam int PLN_W      = 5;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [FMT_W-1:0] FMT_1BPP  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_4BPP  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_8BPP  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_16BPP = 3'd3;
    localparam logic [FMT_W-1:0] FMT_24BPP = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAM    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd3;

    localparam logic [FMT_W-1:0] RST_FORMAT = FMT_8BPP;
    localparam logic [PLN_W-1:0] RST_PLANES = 5'd8;
    localparam logic             RST_HAM    = 1'b0;
    localparam logic [ROW_W-1:0] RST_WIDTH  = 13'd320;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXELS  = 1'b1;

    // Hold-and-modify control field codes, shared by HAM6 and HAM8.
    localparam logic [1:0] HAM_BLUE  = 2'b01;
    localparam logic [1:0] HAM_RED   = 2'b10;
    localparam logic [1:0] HAM_GREEN = 2'b11;

    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [3:0]       nidx;
        logic             direct;
        logic             ham;
        logic             ham6;
    } t_mode;

    typedef struct packed {
        logic                 valid;
        logic                 emit;
        logic                 color;
        logic                 ham;
        logic                 ham6;
        logic                 direct;
        logic                 fmt24;
        logic                 row_end;
        logic                 group_last;
        logic                 clear;
        logic [7:0]           raw;
        logic [PAL_IDX_W-1:0] idx;
        logic [RGB_W-1:0]     rgb;
    } t_tok;

    typedef struct packed {
        logic                 valid;
        logic [PAL_IDX_W-1:0] addr;
        logic [RGB_W-1:0]     rgb;
    } t_pal_wr;

endpackage

// ===== design/p2c_in_if.sv =====
interface p2c_in_if import p2c_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [PAL_IDX_W-1:0] palette_index;
    logic [RGB_W-1:0]     palette_rgb;
    logic [PLANE_W-1:0]   planes_low;
    logic [PLANE_W-1:0]   planes_mid;
    logic [PLANE_W-1:0]   planes_high;

    modport source (
        output valid, cmd, palette_index, palette_rgb, planes_low, planes_mid, planes_high,
        input  ready
    );
    modport sink (
        input  valid, cmd, palette_index, palette_rgb, planes_low, planes_mid, planes_high,
        output ready
    );
endinterface

// ===== design/p2c_out_if.sv =====
interface p2c_out_if import p2c_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] out_data;
    logic [1:0]       out_bytes;
    logic             row_end;
    logic             group_last;

    modport source (
        output valid, out_data, out_bytes, row_end, group_last,
        input  ready
    );
    modport sink (
        input  valid, out_data, out_bytes, row_end, group_last,
        output ready
    );
endinterface

// ===== design/p2c_cfg_if.sv =====
interface p2c_cfg_if import p2c_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== design/p2c_lane.sv =====
module p2c_lane import p2c_pkg::*; #(
    parameter int PIX = 0
) (
    input  logic [PLANE_BITS-1:0] i_planes,
    input  t_mode                 i_mode,
    output logic [PAL_IDX_W-1:0]  o_idx,
    output logic [RGB_W-1:0]      o_rgb
);

    localparam int BITPOS = 7 - PIX;

    logic [RGB_W-1:0]     w_bits;
    logic [PAL_IDX_W-1:0] w_mask;

    always_comb begin
        for (int k = 0; k < RGB_W; k++) begin
            w_bits[k] = i_planes[8 * k + BITPOS];
        end
    end

    assign w_mask = PAL_IDX_W'((9'd1 << i_mode.nidx) - 9'd1);
    assign o_idx  = i_mode.direct ? '0 : (w_bits[7:0] & w_mask);
    assign o_rgb  = {w_bits[7:0], w_bits[15:8], w_bits[23:16]};

endmodule

// ===== design/p2c_seq.sv =====
module p2c_seq import p2c_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    p2c_in_if.sink           i_in,
    input  t_mode            i_mode,
    input  logic [ROW_W-1:0] i_row_width,
    input  logic             i_adv,
    output t_tok             o_tok,
    output t_pal_wr          o_pal_wr
);

    localparam int PW = $clog2(MAX_WIDTH);
    localparam int CW = (PW + 1 > ROW_W) ? PW + 1 : ROW_W;
    localparam logic [CW-1:0] WMAX = CW'(MAX_WIDTH);

    logic [PLANE_BITS-1:0] w_planes;
    logic [PAL_IDX_W-1:0]  w_lidx [8];
    logic [RGB_W-1:0]      w_lrgb [8];

    logic                 r_busy;
    logic                 r_cmd;
    logic [PAL_IDX_W-1:0] r_pal_idx;
    logic [RGB_W-1:0]     r_pal_rgb;
    logic [PAL_IDX_W-1:0] r_idx [8];
    logic [RGB_W-1:0]     r_rgb [8];
    logic [7:0]           r_p0;
    logic [2:0]           r_step;
    logic [PW-1:0]        r_pos;
    logic [4:0]           r_pend;

    logic [PW-1:0] n_pos;
    logic [4:0]    n_pend;

    logic [CW-1:0] w_rw;
    logic [CW-1:0] w_w;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_pos1;
    logic [CW-1:0] w_pos2;
    logic          w_end;
    logic          w_end7;
    logic [CW-1:0] w_left;
    logic [3:0]    w_cnt;
    logic [7:0]    w_mask;
    logic          w_rend;
    logic          w_last_step;
    logic          w_done;
    logic          w_accept;

    assign w_planes = {i_in.planes_high, i_in.planes_mid, i_in.planes_low};

    for (genvar j = 0; j < 8; j++) begin : g_lane
        p2c_lane #(
            .PIX (j)
        ) u_lane (
            .i_planes (w_planes),
            .i_mode   (i_mode),
            .o_idx    (w_lidx[j]),
            .o_rgb    (w_lrgb[j])
        );
    end

    assign w_rw   = CW'(i_row_width);
    assign w_w    = (w_rw == '0) ? CW'(1) : ((w_rw > WMAX) ? WMAX : w_rw);
    assign w_pos  = CW'(r_pos);
    assign w_pos1 = w_pos + CW'(1);
    assign w_pos2 = w_pos + CW'(2);
    assign w_end  = w_pos1 >= w_w;
    assign w_end7 = w_pos2 >= w_w;

    assign w_left = (w_pos >= w_w) ? CW'(1) : (w_w - w_pos);
    assign w_cnt  = (w_left < CW'(8)) ? w_left[3:0] : 4'd8;
    assign w_mask = ~(8'hFF >> w_cnt);
    assign w_rend = CW'(w_cnt) == w_left;

    assign w_last_step = r_step == 3'd7;

    always_comb begin
        o_tok        = '0;
        o_tok.valid  = r_busy;
        o_tok.idx    = r_idx[0];
        o_tok.rgb    = r_rgb[0];
        o_tok.direct = i_mode.direct;
        o_tok.ham6   = i_mode.ham6;
        n_pos        = r_pos;
        n_pend       = r_pend;
        w_done       = 1'b1;
        if (r_cmd == CMD_PIXELS) begin
            if (i_mode.fmt == FMT_1BPP) begin
                o_tok.emit       = 1'b1;
                o_tok.raw        = r_p0 & w_mask;
                o_tok.row_end    = w_rend;
                o_tok.group_last = 1'b1;
                o_tok.clear      = w_rend;
                n_pos            = w_rend ? '0 : PW'(w_pos + CW'(w_cnt));
                n_pend           = w_rend ? '0 : r_pend;
            end else begin
                w_done        = w_end || w_last_step;
                n_pos         = w_end ? '0 : PW'(w_pos1);
                o_tok.clear   = w_end;
                o_tok.row_end = w_end;
                case (i_mode.fmt) inside
                    FMT_4BPP: begin
                        o_tok.emit       = r_pend[4] || w_end;
                        o_tok.raw        = r_pend[4] ? {r_pend[3:0], r_idx[0][3:0]}
                                                     : {r_idx[0][3:0], 4'b0};
                        o_tok.group_last = w_done || (r_step == 3'd6 && !w_end7);
                        n_pend           = r_pend[4] ? '0 : {1'b1, r_idx[0][3:0]};
                    end
                    FMT_8BPP: begin
                        o_tok.emit       = 1'b1;
                        o_tok.raw        = r_idx[0];
                        o_tok.group_last = w_done;
                    end
                    FMT_16BPP, FMT_24BPP: begin
                        o_tok.emit       = 1'b1;
                        o_tok.color      = 1'b1;
                        o_tok.ham        = i_mode.ham;
                        o_tok.fmt24      = i_mode.fmt == FMT_24BPP;
                        o_tok.group_last = w_done;
                    end
                    default: begin
                    end
                endcase
                if (w_end) begin
                    n_pend = '0;
                end
            end
        end
    end

    assign o_pal_wr.valid = r_busy && r_cmd == CMD_PALETTE;
    assign o_pal_wr.addr  = r_pal_idx;
    assign o_pal_wr.rgb   = r_pal_rgb;

    assign i_in.ready = !r_busy || (i_adv && w_done);
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_pend <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (r_busy && i_adv && w_done) begin
                r_busy <= 1'b0;
            end
            if (r_busy && i_adv) begin
                r_pos  <= n_pos;
                r_pend <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_in.cmd;
            r_pal_idx <= i_in.palette_index;
            r_pal_rgb <= i_in.palette_rgb;
            r_p0      <= i_in.planes_low[7:0];
            r_step    <= '0;
            for (int i = 0; i < 8; i++) begin
                r_idx[i] <= w_lidx[i];
                r_rgb[i] <= w_lrgb[i];
            end
        end else if (r_busy && i_adv) begin
            r_step <= r_step + 3'd1;
            for (int i = 0; i < 7; i++) begin
                r_idx[i] <= r_idx[i + 1];
                r_rgb[i] <= r_rgb[i + 1];
            end
        end
    end

endmodule

// ===== design/p2c_merge.sv =====
module p2c_merge import p2c_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tok     i_tok,
    input  t_pal_wr  i_pal_wr,
    output logic     o_adv,
    p2c_out_if.source o_out
);

    localparam int PA = $clog2(PALETTE_DEPTH);
    localparam logic [PAL_IDX_W:0] DEPTH = (PAL_IDX_W + 1)'(PALETTE_DEPTH);

    logic [RGB_W-1:0] r_mem [PALETTE_DEPTH];
    logic [RGB_W-1:0] r_pal_q;
    logic             r_pal_ok;
    logic             r_tv;
    t_tok             r_tok;
    logic [RGB_W-1:0] r_held;
    logic             r_ov;
    logic [RGB_W-1:0] r_od;
    logic [1:0]       r_ob;
    logic             r_ore;
    logic             r_ogl;

    logic [RGB_W-1:0] n_held;

    logic             w_wr_ok;
    logic             w_rd_ok;
    logic [RGB_W-1:0] w_pal;
    logic [7:0]       w_r;
    logic [7:0]       w_g;
    logic [7:0]       w_b;
    logic [7:0]       w_v6;
    logic             w_ham_pal;
    logic [RGB_W-1:0] w_color;
    logic [RGB_W-1:0] w_data;
    logic [1:0]       w_bytes;

    assign o_adv   = !r_ov || o_out.ready;
    assign w_wr_ok = {1'b0, i_pal_wr.addr} < DEPTH;
    assign w_rd_ok = {1'b0, i_tok.idx} < DEPTH;

    always_ff @(posedge i_clk) begin
        if (o_adv && i_pal_wr.valid && w_wr_ok) begin
            r_mem[i_pal_wr.addr[PA-1:0]] <= i_pal_wr.rgb;
        end
        if (o_adv) begin
            r_pal_q  <= r_mem[i_tok.idx[PA-1:0]];
            r_pal_ok <= w_rd_ok;
            r_tok    <= i_tok;
        end
    end

    always_comb begin
        w_pal     = r_pal_ok ? r_pal_q : '0;
        w_r       = r_held[23:16];
        w_g       = r_held[15:8];
        w_b       = r_held[7:0];
        w_v6      = {r_tok.idx[3:0], r_tok.idx[3:0]};
        w_ham_pal = 1'b0;
        if (r_tok.ham6) begin
            unique case (r_tok.idx[5:4])
                HAM_RED:   w_r = w_v6;
                HAM_GREEN: w_g = w_v6;
                HAM_BLUE:  w_b = w_v6;
                default:   w_ham_pal = 1'b1;
            endcase
        end else begin
            unique case (r_tok.idx[7:6])
                HAM_RED:   w_r = {r_tok.idx[5:0], w_r[1:0]};
                HAM_GREEN: w_g = {r_tok.idx[5:0], w_g[1:0]};
                HAM_BLUE:  w_b = {r_tok.idx[5:0], w_b[1:0]};
                default:   w_ham_pal = 1'b1;
            endcase
        end

        if (r_tok.ham) begin
            w_color = w_ham_pal ? w_pal : {w_r, w_g, w_b};
        end else begin
            w_color = r_tok.direct ? r_tok.rgb : w_pal;
        end

        if (!r_tok.color) begin
            w_data  = {16'b0, r_tok.raw};
            w_bytes = 2'd1;
        end else if (r_tok.fmt24) begin
            w_data  = w_color;
            w_bytes = 2'd3;
        end else begin
            w_data  = {9'b0, w_color[23:19], w_color[15:11], w_color[7:3]};
            w_bytes = 2'd2;
        end

        if (r_tok.clear) begin
            n_held = '0;
        end else if (r_tok.ham) begin
            n_held = w_color;
        end else begin
            n_held = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv   <= 1'b0;
            r_ov   <= 1'b0;
            r_held <= '0;
        end else if (o_adv) begin
            r_tv <= i_tok.valid;
            r_ov <= r_tv && r_tok.emit;
            if (r_tv) begin
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_od  <= w_data;
            r_ob  <= w_bytes;
            r_ore <= r_tok.row_end;
            r_ogl <= r_tok.group_last;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_data   = r_od;
    assign o_out.out_bytes  = r_ob;
    assign o_out.row_end    = r_ore;
    assign o_out.group_last = r_ogl;

endmodule

// ===== design/planar_to_chunky_ham_decoder.sv =====
// Bitplane to chunky pixel converter with HAM6 and HAM8 support.
// Channels: i_in takes palette writes (cmd 0) and groups of eight pixels
// given as one byte per bitplane (cmd 1). o_out delivers packed output
// bytes with the row end and group end marks. i_cfg writes the four mode
// registers and is always ready; write it only while the block is idle.
// Eight lanes gather the plane bits of the eight pixels in parallel at the
// input transfer, and a sequencer then walks the pixels one per cycle, while
// the output is not stalled, through the palette read, the hold-and-modify
// stage and the packer; in 1 bpp mode a group passes as one byte. An input
// transfer is registered in the sequencer, then in the palette read stage,
// then in the output register. A group holds the sequencer up to its last
// pixel or the row end, and the next item is taken in the cycle it finishes.
// Reset restores the mode registers to their defaults and clears the row
// position, the held color and the pending nibble. Palette contents are
// undefined until written. When the receiver stalls a valid output, the
// output register holds its transfer and the pipeline waits, though an
// idle sequencer still takes a new input item.
module planar_to_chunky_ham_decoder import p2c_pkg::*; #(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    p2c_in_if.sink    i_in,
    p2c_out_if.source o_out,
    p2c_cfg_if.sink   i_cfg
);

    logic [FMT_W-1:0] r_fmt;
    logic [PLN_W-1:0] r_planes;
    logic             r_ham;
    logic [ROW_W-1:0] r_width;

    logic [PLN_W-1:0] w_np;
    t_mode            w_mode;
    t_tok             w_tok;
    t_pal_wr          w_pal_wr;
    logic             w_adv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= RST_FORMAT;
            r_planes <= RST_PLANES;
            r_ham    <= RST_HAM;
            r_width  <= RST_WIDTH;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FORMAT: r_fmt    <= i_cfg.data[FMT_W-1:0];
                CFG_PLANES: r_planes <= i_cfg.data[PLN_W-1:0];
                CFG_HAM:    r_ham    <= i_cfg.data[0];
                CFG_WIDTH:  r_width  <= i_cfg.data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_np = (r_planes > PLN_W'(MAX_PLANES)) ? PLN_W'(MAX_PLANES) : r_planes;

    assign w_mode.fmt    = r_fmt;
    assign w_mode.nidx   = (w_np > 5'd8) ? 4'd8 : w_np[3:0];
    assign w_mode.direct = w_np >= 5'd24;
    assign w_mode.ham    = r_ham;
    assign w_mode.ham6   = w_np == 5'd6;

    p2c_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_mode      (w_mode),
        .i_row_width (r_width),
        .i_adv       (w_adv),
        .o_tok       (w_tok),
        .o_pal_wr    (w_pal_wr)
    );

    p2c_merge #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (w_tok),
        .i_pal_wr (w_pal_wr),
        .o_adv    (w_adv),
        .o_out    (o_out)
    );

`ifndef ASSERT_OFF
    a_row_end_ends_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.row_end |-> o_out.group_last)
        else $error("row end transfer not marked as last of its group");

    a_bytes_match_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.out_bytes == 2'd3) == (r_fmt == FMT_24BPP)))
        else $error("output byte count does not match the output format");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== bench/tb_planar_to_chunky_ham_decoder.sv =====
module tb_planar_to_chunky_ham_decoder;
    import p2c_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLDOFF_CYCLES = 160;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 160;

    localparam logic [FMT_W-1:0] FMT_UNDEF_LO = 3'd5;
    localparam logic [FMT_W-1:0] FMT_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic                  cmd;
        logic [PAL_IDX_W-1:0]  pal_idx;
        logic [RGB_W-1:0]      pal_rgb;
        logic [PLANE_BITS-1:0] planes;
    } p2c_item_t;

    typedef struct packed {
        logic [RGB_W-1:0] data;
        logic [1:0]       nbytes;
        logic             row_end;
        logic             group_last;
    } pix_out_t;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_RARE} stall_mode_t;

    logic i_clk;
    logic i_rst_n;

    p2c_in_if  in_ch ();
    p2c_out_if out_ch ();
    p2c_cfg_if cfg_ch ();

    planar_to_chunky_ham_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    p2c_item_t planar_items[$];
    pix_out_t  expected_pixels[$];

    logic [RGB_W-1:0] pal_shadow [PALETTE_DEPTH_DEF];
    logic [RGB_W-1:0] held_rgb;
    logic [11:0]      row_pos;
    logic             nib_valid;
    logic [3:0]       nib_val;
    logic [FMT_W-1:0] cfg_fmt;
    logic [PLN_W-1:0] cfg_planes;
    logic             cfg_ham;
    logic [ROW_W-1:0] cfg_width;

    int mismatch_count = 0;
    int burst_left;
    int gap_left;
    int holdoff_req = 0;
    int holdoff_ack;
    int holdoff_left;
    int stretch_left;
    int ready_tick = 0;
    int quiet_cycles;
    stall_mode_t stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic pix_out_t make_out(input logic [RGB_W-1:0] data, input logic [1:0] nbytes,
                                          input logic rend);
        pix_out_t o;
        o.data       = data;
        o.nbytes     = nbytes;
        o.row_end    = rend;
        o.group_last = 1'b0;
        return o;
    endfunction

    function automatic logic [RGB_W-1:0] ham_color(input logic [7:0] idx, input logic ham6);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [1:0] ctl;
        r = held_rgb[23:16];
        g = held_rgb[15:8];
        b = held_rgb[7:0];
        ctl = ham6 ? idx[5:4] : idx[7:6];
        case (ctl)
            HAM_RED:   r = ham6 ? {idx[3:0], idx[3:0]} : {idx[5:0], r[1:0]};
            HAM_GREEN: g = ham6 ? {idx[3:0], idx[3:0]} : {idx[5:0], g[1:0]};
            HAM_BLUE:  b = ham6 ? {idx[3:0], idx[3:0]} : {idx[5:0], b[1:0]};
            default:   return pal_shadow[idx];
        endcase
        return {r, g, b};
    endfunction

    task automatic convert_item(input p2c_item_t it);
        pix_out_t         grp [9];
        int               n;
        int               np;
        int               w;
        int               nidx;
        int               pos;
        int               left;
        int               cnt;
        int               p;
        int               k;
        int               n_prev;
        logic             direct;
        logic [15:0]      shifted;
        logic [7:0]       idx;
        logic [RGB_W-1:0] rgb;
        logic [RGB_W-1:0] c;
        if (it.cmd == CMD_PALETTE) begin
            pal_shadow[it.pal_idx] = it.pal_rgb;
            return;
        end
        n = 0;
        np = int'(cfg_planes);
        if (np > MAX_PLANES) np = MAX_PLANES;
        w = int'(cfg_width);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        direct = (np >= 24);
        nidx = (np > 8) ? 8 : np;
        pos = int'(row_pos);

        if (cfg_fmt == FMT_1BPP) begin
            left = (pos >= w) ? 1 : w - pos;
            cnt = (left < 8) ? left : 8;
            shifted = 16'hFF00 >> cnt;
            grp[0] = make_out({16'h0000, it.planes[7:0] & shifted[7:0]}, 2'd1, cnt == left);
            grp[0].group_last = 1'b1;
            expected_pixels.push_back(grp[0]);
            if (cnt == left) begin
                pos = 0;
                held_rgb = '0;
                nib_valid = 1'b0;
                nib_val = 4'h0;
            end else begin
                pos = pos + cnt;
            end
            row_pos = pos[11:0];
            return;
        end

        for (p = 0; p < 8; p++) begin
            idx = 8'h00;
            rgb = '0;
            if (!direct) begin
                for (k = 0; k < nidx; k++) idx[k] = it.planes[8*k + 7 - p];
            end else begin
                for (k = 0; k < 8; k++) begin
                    rgb[16+k] = it.planes[8*k + 7 - p];
                    rgb[8+k]  = it.planes[64 + 8*k + 7 - p];
                    rgb[k]    = it.planes[128 + 8*k + 7 - p];
                end
            end
            n_prev = n;
            case (cfg_fmt)
                FMT_4BPP: begin
                    if (nib_valid) begin
                        grp[n] = make_out({16'h0000, nib_val, idx[3:0]}, 2'd1, 1'b0);
                        n++;
                        nib_valid = 1'b0;
                        nib_val = 4'h0;
                    end else begin
                        nib_valid = 1'b1;
                        nib_val = idx[3:0];
                    end
                end
                FMT_8BPP: begin
                    grp[n] = make_out({16'h0000, idx}, 2'd1, 1'b0);
                    n++;
                end
                FMT_16BPP, FMT_24BPP: begin
                    if (cfg_ham) begin
                        held_rgb = ham_color(idx, np == 6);
                        c = held_rgb;
                    end else if (direct) begin
                        c = rgb;
                    end else begin
                        c = pal_shadow[idx];
                    end
                    if (cfg_fmt == FMT_16BPP)
                        grp[n] = make_out({9'h000, c[23:19], c[15:11], c[7:3]}, 2'd2, 1'b0);
                    else
                        grp[n] = make_out(c, 2'd3, 1'b0);
                    n++;
                end
                default: ;
            endcase
            if (pos + 1 >= w) begin
                if (cfg_fmt == FMT_4BPP && nib_valid) begin
                    grp[n] = make_out({16'h0000, nib_val, 4'h0}, 2'd1, 1'b1);
                    n++;
                end else if (n > n_prev) begin
                    grp[n-1].row_end = 1'b1;
                end
                pos = 0;
                held_rgb = '0;
                nib_valid = 1'b0;
                nib_val = 4'h0;
                break;
            end
            pos = pos + 1;
        end
        row_pos = pos[11:0];
        if (n > 0) grp[n-1].group_last = 1'b1;
        for (k = 0; k < n; k++) expected_pixels.push_back(grp[k]);
    endtask

    always @(posedge i_clk) begin
        p2c_item_t seen;
        pix_out_t  want;
        if (!i_rst_n) begin
            cfg_fmt = RST_FORMAT;
            cfg_planes = RST_PLANES;
            cfg_ham = RST_HAM;
            cfg_width = RST_WIDTH;
            held_rgb = '0;
            row_pos = '0;
            nib_valid = 1'b0;
            nib_val = 4'h0;
            expected_pixels.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_FORMAT: cfg_fmt = cfg_ch.data[FMT_W-1:0];
                    CFG_PLANES: cfg_planes = cfg_ch.data[PLN_W-1:0];
                    CFG_HAM:    cfg_ham = cfg_ch.data[0];
                    CFG_WIDTH:  cfg_width = cfg_ch.data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                seen.cmd = in_ch.cmd;
                seen.pal_idx = in_ch.palette_index;
                seen.pal_rgb = in_ch.palette_rgb;
                seen.planes = {in_ch.planes_high, in_ch.planes_mid, in_ch.planes_low};
                convert_item(seen);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("out transfer with nothing expected: out_data %h", out_ch.out_data);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_ch.out_data !== want.data) begin
                        $error("out_data: expected %h, actual %h", want.data, out_ch.out_data);
                        mismatch_count++;
                    end
                    if (out_ch.out_bytes !== want.nbytes) begin
                        $error("out_bytes: expected %0d, actual %0d", want.nbytes,
                               out_ch.out_bytes);
                        mismatch_count++;
                    end
                    if (out_ch.row_end !== want.row_end) begin
                        $error("row_end: expected %b, actual %b", want.row_end, out_ch.row_end);
                        mismatch_count++;
                    end
                    if (out_ch.group_last !== want.group_last) begin
                        $error("group_last: expected %b, actual %b", want.group_last,
                               out_ch.group_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        p2c_item_t next_item;
        logic      load;
        load = 1'b0;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (planar_items.size() > 0) begin
                next_item = planar_items.pop_front();
                load = 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
            in_ch.valid <= load;
            if (load) begin
                in_ch.cmd <= next_item.cmd;
                in_ch.palette_index <= next_item.pal_idx;
                in_ch.palette_rgb <= next_item.pal_rgb;
                in_ch.planes_low <= next_item.planes[63:0];
                in_ch.planes_mid <= next_item.planes[127:64];
                in_ch.planes_high <= next_item.planes[191:128];
            end
        end
    end

    always @(posedge i_clk) begin
        logic take;
        ready_tick <= ready_tick + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            holdoff_ack <= 0;
            holdoff_left <= 0;
            stretch_left <= 0;
            stall_mode <= STALL_NONE;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            out_ch.ready <= 1'b0;
        end else if (holdoff_ack != holdoff_req) begin
            holdoff_ack <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                stretch_left <= $urandom_range(10, 80);
            end else begin
                stretch_left <= stretch_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  take = 1'b1;
                STALL_COIN:  take = ($urandom_range(0, 1) == 1);
                STALL_THIRD: take = (ready_tick % 3 == 0);
                default:     take = ($urandom_range(0, 7) != 0);
            endcase
            out_ch.ready <= take;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [PLANE_BITS-1:0] rand_planes();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Leftmost pixel's index sits in the top byte of pix.
    function automatic logic [PLANE_BITS-1:0] planes_of(input logic [63:0] pix);
        logic [PLANE_BITS-1:0] pl;
        int                    p;
        int                    k;
        pl = rand_planes();
        for (p = 0; p < 8; p++)
            for (k = 0; k < 8; k++)
                pl[8*k + 7 - p] = pix[56 - 8*p + k];
        return pl;
    endfunction

    task automatic push_group(input logic [PLANE_BITS-1:0] planes);
        p2c_item_t it;
        it.cmd = CMD_PIXELS;
        it.pal_idx = PAL_IDX_W'($urandom);
        it.pal_rgb = RGB_W'($urandom);
        it.planes = planes;
        planar_items.push_back(it);
    endtask

    task automatic push_palette(input logic [PAL_IDX_W-1:0] idx, input logic [RGB_W-1:0] rgb);
        p2c_item_t it;
        it.cmd = CMD_PALETTE;
        it.pal_idx = idx;
        it.pal_rgb = rgb;
        it.planes = rand_planes();
        planar_items.push_back(it);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (planar_items.size() != 0 || in_ch.valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_mode(input logic [FMT_W-1:0] fmt, input logic [PLN_W-1:0] planes,
                            input logic ham, input logic [ROW_W-1:0] width);
        wait_idle();
        write_reg(CFG_FORMAT, CFG_DATA_W'(fmt));
        write_reg(CFG_PLANES, CFG_DATA_W'(planes));
        write_reg(CFG_HAM, CFG_DATA_W'(ham));
        write_reg(CFG_WIDTH, width);
    endtask

    initial begin
        int               i;
        int               r;
        int               phase;
        int               sent;
        int               n_items;
        logic [FMT_W-1:0] fmt;
        logic [PLN_W-1:0] planes;
        logic             ham;
        logic [ROW_W-1:0] width;

        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_PALETTE;
        in_ch.palette_index = '0;
        in_ch.palette_rgb = '0;
        in_ch.planes_low = '0;
        in_ch.planes_mid = '0;
        in_ch.planes_high = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_FORMAT;
        cfg_ch.data = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every palette entry is loaded before any color lookup can reach it.
        for (i = 0; i < PALETTE_DEPTH_DEF; i++) begin
            if (i == 0)
                push_palette(i[7:0], 24'h000000);
            else if (i == PALETTE_DEPTH_DEF - 1)
                push_palette(i[7:0], 24'hFFFFFF);
            else
                push_palette(i[7:0], RGB_W'($urandom));
        end
        push_group('0);
        push_group('1);

        set_mode(FMT_1BPP, 5'd1, 1'b0, 13'd13);
        repeat (3) push_group(rand_planes());
        set_mode(FMT_4BPP, 5'd4, 1'b0, 13'd7);
        repeat (2) push_group(rand_planes());
        set_mode(FMT_16BPP, 5'd8, 1'b0, 13'd20);
        push_group(planes_of(64'h00_01_7F_80_FE_FF_55_AA));
        set_mode(FMT_16BPP, 5'd24, 1'b0, 13'd20);
        push_group(rand_planes());
        set_mode(FMT_24BPP, 5'd24, 1'b0, 13'd20);
        push_group(rand_planes());
        set_mode(FMT_24BPP, 5'd0, 1'b0, 13'd20);
        push_group(rand_planes());
        set_mode(FMT_16BPP, 5'd6, 1'b1, 13'd12);
        push_group(planes_of(64'h2F_3A_15_07_20_3F_1C_00));
        push_group(planes_of(64'h31_2E_1A_09_3C_25_13_0B));
        push_group(planes_of(64'h2F_3A_15_07_20_3F_1C_00));
        set_mode(FMT_24BPP, 5'd8, 1'b1, 13'd64);
        push_group(planes_of(64'h80_C0_40_05_BF_FF_7F_3C));
        push_group(planes_of(64'h81_C2_43_00_AA_E5_55_01));
        set_mode(FMT_24BPP, 5'd24, 1'b1, 13'd64);
        push_group(rand_planes());
        set_mode(FMT_8BPP, 5'd31, 1'b0, 13'd0);
        push_group(rand_planes());
        set_mode(FMT_4BPP, 5'd3, 1'b0, 13'd1);
        push_group(rand_planes());
        set_mode(FMT_UNDEF_LO, 5'd8, 1'b0, 13'd8191);
        repeat (2) push_group(rand_planes());
        set_mode(FMT_8BPP, 5'd8, 1'b0, 13'd10);
        repeat (2) push_group(rand_planes());
        set_mode(FMT_UNDEF_HI, 5'd8, 1'b0, 13'd320);
        push_group(rand_planes());

        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 15);
            if (r < 14) fmt = FMT_W'(r % 5);
            else fmt = FMT_W'($urandom_range(5, 7));

            r = $urandom_range(0, 9);
            if (r < 4) planes = PLN_W'($urandom_range(1, 8));
            else if (r < 6) planes = 5'd24;
            else if (r == 6) planes = 5'd6;
            else if (r == 7) planes = 5'd8;
            else if (r == 8) planes = PLN_W'($urandom_range(9, 23));
            else if ($urandom_range(0, 1) == 1) planes = 5'd0;
            else planes = PLN_W'($urandom_range(25, 31));

            ham = 1'($urandom_range(0, 1));

            r = $urandom_range(0, 9);
            if (r < 6) width = ROW_W'($urandom_range(1, 40));
            else if (r == 6) width = ROW_W'($urandom_range(41, 400));
            else if (r == 7) width = ROW_W'($urandom_range(4090, 4096));
            else if (r == 8 && $urandom_range(0, 1) == 1) width = 13'd0;
            else if (r == 8) width = ROW_W'($urandom_range(4097, 8191));
            else width = ROW_W'($urandom_range(1, 3));

            set_mode(fmt, planes, ham, width);
            n_items = $urandom_range(20, 60);
            for (i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 9) == 0)
                    push_palette(PAL_IDX_W'($urandom), RGB_W'($urandom));
                else
                    push_group(rand_planes());
            end
            sent = sent + n_items;
            if (phase % 4 == 1) holdoff_req = holdoff_req + 1;
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
